// ===== hw/rtl/rgba_pixel_blend_unit_core_assert.svh =====
// Assertion macros for the RGBA pixel blend unit.
// Used by rgba_pixel_blend_unit_core; expects clk and rst in scope.
`ifndef RGBA_PIXEL_BLEND_UNIT_CORE_ASSERT_SVH
`define RGBA_PIXEL_BLEND_UNIT_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define RPBU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define RPBU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RPBU_ASSERT_IMPL(lbl, ante, cons)
`define RPBU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/rpbu_pkg.sv =====
// Package for the RGBA pixel blend unit: blend mode codes and register indexes.
// No dependencies.
package rpbu_pkg;
  localparam logic [3:0] MODE_ALPHA    = 4'd0;
  localparam logic [3:0] MODE_COLOR    = 4'd1;
  localparam logic [3:0] MODE_ADD      = 4'd2;
  localparam logic [3:0] MODE_SUBTRACT = 4'd3;
  localparam logic [3:0] MODE_MULTIPLY = 4'd4;
  localparam logic [3:0] MODE_LIGHTEN  = 4'd5;
  localparam logic [3:0] MODE_DARKEN   = 4'd6;
  localparam logic [3:0] MODE_SCREEN   = 4'd7;
  localparam logic [3:0] MODE_DIFF     = 4'd8;

  localparam logic [2:0] REG_BLEND_MODE   = 3'd0;
  localparam logic [2:0] REG_GLOBAL_ALPHA = 3'd1;
  localparam logic [2:0] REG_TINT_RED     = 3'd2;
  localparam logic [2:0] REG_TINT_GREEN   = 3'd3;
  localparam logic [2:0] REG_TINT_BLUE    = 3'd4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd254;
  localparam logic [7:0] FULL_SCALE   = 8'hff;
endpackage

// ===== hw/rtl/rgba_pixel_blend_unit_core.sv =====
// RGBA8888 blend unit: six-stage pipeline, one pixel beat per clock unless stalled.
// A beat passes through the stage 1 to stage 6 registers in order; a new beat is taken
// whenever in_stall is low, and out_stall holds beats back (the translucent-composite
// divider is split over stages 5 and 6).
// Reset (rst, synchronous): pipeline empties, registers return to alpha mode,
// global alpha 255 and white tint. Depends on rpbu_pkg and the assert header.
`include "rgba_pixel_blend_unit_core_assert.svh"
module rgba_pixel_blend_unit_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] src_red,
  input  logic [7:0] src_green,
  input  logic [7:0] src_blue,
  input  logic [7:0] src_alpha,
  input  logic [7:0] dst_red,
  input  logic [7:0] dst_green,
  input  logic [7:0] dst_blue,
  input  logic [7:0] dst_alpha,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic       written
);
  import rpbu_pkg::*;

  // configuration registers
  logic [3:0] blend_mode;
  logic [7:0] global_alpha;
  logic [7:0] tint [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode   <= MODE_ALPHA;
      global_alpha <= FULL_SCALE;
      tint[0]      <= FULL_SCALE;
      tint[1]      <= FULL_SCALE;
      tint[2]      <= FULL_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLEND_MODE:   blend_mode   <= cfg_data[3:0];
        REG_GLOBAL_ALPHA: global_alpha <= cfg_data;
        REG_TINT_RED:     tint[0]      <= cfg_data;
        REG_TINT_GREEN:   tint[1]      <= cfg_data;
        REG_TINT_BLUE:    tint[2]      <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-stage valid and ready chain; a stage loads when empty or when its
  // downstream neighbor loads
  logic [6:1] v;
  logic [6:1] rdy;

  always_comb begin
    rdy[6] = !v[6] || !out_stall;
    for (int k = 5; k >= 1; k--) rdy[k] = !v[k] || rdy[k+1];
  end

  assign in_stall  = !rdy[1];
  assign out_valid = v[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      for (int k = 2; k <= 6; k++) if (rdy[k]) v[k] <= v[k-1];
    end
  end

  // ---------------- stage 1: effective alpha, tint ----------------
  logic [7:0]  src_c [3];
  logic [7:0]  dst_in [4];
  logic [15:0] ea_prod;
  logic [15:0] tint_prod [3];
  logic        tint_on;

  assign src_c[0]  = src_red;
  assign src_c[1]  = src_green;
  assign src_c[2]  = src_blue;
  assign dst_in[0] = dst_red;
  assign dst_in[1] = dst_green;
  assign dst_in[2] = dst_blue;
  assign dst_in[3] = dst_alpha;
  assign ea_prod   = 16'(src_alpha) * 16'(global_alpha);
  assign tint_on   = (tint[0] != FULL_SCALE) || (tint[1] != FULL_SCALE) ||
                     (tint[2] != FULL_SCALE);
  always_comb begin
    for (int i = 0; i < 3; i++) tint_prod[i] = 16'(src_c[i]) * 16'(tint[i]);
  end

  logic [7:0] a1;
  logic [7:0] s1 [4];
  logic [7:0] d1 [4];

  always_ff @(posedge clk) begin
    if (rdy[1] && in_valid) begin
      a1    <= ea_prod[15:8];
      s1[3] <= src_alpha;
      for (int i = 0; i < 3; i++) s1[i] <= tint_on ? tint_prod[i][15:8] : src_c[i];
      for (int i = 0; i < 4; i++) d1[i] <= dst_in[i];
    end
  end

  // ---------------- stage 2: blend mode ----------------
  logic [9:0]  ssum, dsum;
  logic [7:0]  b_next [4];
  logic [15:0] mul_prod [3];
  logic [15:0] scr_prod [3];
  logic [8:0]  add_sum [3];

  assign ssum = 10'(s1[0]) + 10'(s1[1]) + 10'(s1[2]);
  assign dsum = 10'(d1[0]) + 10'(d1[1]) + 10'(d1[2]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mul_prod[i] = 16'(s1[i]) * 16'(d1[i]);
      scr_prod[i] = 16'(FULL_SCALE - d1[i]) * 16'(FULL_SCALE - s1[i]);
      add_sum[i]  = 9'(s1[i]) + 9'(d1[i]);
    end
    for (int i = 0; i < 4; i++) b_next[i] = s1[i];
    case (blend_mode)
      MODE_COLOR: begin
        for (int i = 0; i < 3; i++) b_next[i] = tint[i];
        b_next[3] = 8'd0;
      end
      MODE_ADD:
        for (int i = 0; i < 3; i++) b_next[i] = add_sum[i][8] ? FULL_SCALE : add_sum[i][7:0];
      MODE_SUBTRACT:
        for (int i = 0; i < 3; i++) b_next[i] = (d1[i] > s1[i]) ? d1[i] - s1[i] : 8'd0;
      MODE_MULTIPLY:
        for (int i = 0; i < 3; i++) b_next[i] = mul_prod[i][15:8];
      MODE_LIGHTEN:
        if (!(ssum > dsum)) for (int i = 0; i < 4; i++) b_next[i] = d1[i];
      MODE_DARKEN:
        if (!(ssum < dsum)) for (int i = 0; i < 4; i++) b_next[i] = d1[i];
      MODE_SCREEN:
        for (int i = 0; i < 3; i++) b_next[i] = FULL_SCALE - scr_prod[i][15:8];
      MODE_DIFF:
        for (int i = 0; i < 3; i++)
          b_next[i] = (s1[i] >= d1[i]) ? s1[i] - d1[i] : d1[i] - s1[i];
      default: ;
    endcase
  end

  logic [7:0] a2;
  logic [7:0] b2 [4];
  logic [7:0] d2 [4];

  always_ff @(posedge clk) begin
    if (rdy[2] && v[1]) begin
      a2 <= a1;
      for (int i = 0; i < 4; i++) begin
        b2[i] <= b_next[i];
        d2[i] <= d1[i];
      end
    end
  end

  // ---------------- stage 3: path products ----------------
  logic [15:0] lerp_prod [3];
  logic [15:0] oa_prod, z_prod;
  logic [15:0] sa_prod [3];

  assign oa_prod = 16'(FULL_SCALE - d2[3]) * 16'(FULL_SCALE - a2);
  assign z_prod  = 16'(d2[3]) * 16'(FULL_SCALE - a2);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lerp_prod[i] = (b2[i] >= d2[i]) ? 16'(b2[i] - d2[i]) * 16'(a2)
                                      : 16'(d2[i] - b2[i]) * 16'(a2);
      sa_prod[i]   = 16'(b2[i]) * 16'(a2);
    end
  end

  logic [7:0]  a3, oa3, z3;
  logic [7:0]  b3 [4];
  logic [7:0]  d3 [4];
  logic [15:0] lp3 [3];
  logic [2:0]  lge3;
  logic [7:0]  sa3 [3];

  always_ff @(posedge clk) begin
    if (rdy[3] && v[2]) begin
      a3  <= a2;
      oa3 <= FULL_SCALE - oa_prod[15:8];
      z3  <= z_prod[15:8];
      for (int i = 0; i < 4; i++) begin
        b3[i] <= b2[i];
        d3[i] <= d2[i];
      end
      for (int i = 0; i < 3; i++) begin
        lp3[i]  <= lerp_prod[i];
        lge3[i] <= b2[i] >= d2[i];
        sa3[i]  <= sa_prod[i][15:8];
      end
    end
  end

  // ---------------- stage 4: numerators, lerp, path choice ----------------
  logic [15:0] dz_prod [3];
  logic [16:0] lp_round [3];
  logic [7:0]  res_next [4];
  logic        wr_next, div_next;

  always_comb begin
    wr_next  = a3 > 8'd1;
    div_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dz_prod[i]  = 16'(d3[i]) * 16'(z3);
      lp_round[i] = 17'(lp3[i]) + 17'(FULL_SCALE);
    end
    if (!wr_next) begin
      for (int i = 0; i < 4; i++) res_next[i] = d3[i];
    end else if (a3 >= ALPHA_OPAQUE) begin
      for (int i = 0; i < 4; i++) res_next[i] = b3[i];
    end else if (d3[3] >= ALPHA_OPAQUE) begin
      for (int i = 0; i < 3; i++)
        res_next[i] = lge3[i] ? d3[i] + lp3[i][15:8] : d3[i] - lp_round[i][15:8];
      res_next[3] = d3[3];
    end else begin
      // translucent destination: finished by the divider stages
      for (int i = 0; i < 4; i++) res_next[i] = d3[i];
      div_next = 1'b1;
    end
  end

  logic [8:0] n4 [3];
  logic [7:0] oa4;
  logic [7:0] res4 [4];
  logic       wr4, div4;

  always_ff @(posedge clk) begin
    if (rdy[4] && v[3]) begin
      oa4  <= oa3;
      wr4  <= wr_next;
      div4 <= div_next;
      for (int i = 0; i < 4; i++) res4[i] <= res_next[i];
      for (int i = 0; i < 3; i++) n4[i] <= 9'(dz_prod[i][15:8]) + 9'(sa3[i]);
    end
  end

  // ---------------- stage 5: n mod oa (restoring, integer part) ----------------
  // floor((n << 8) / oa) mod 256 equals floor(((n mod oa) << 8) / oa).
  logic [8:0] rem5 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem5[i] = '0;
      for (int b = 8; b >= 0; b--) begin
        rem5[i] = {rem5[i][7:0], n4[i][b]};
        if (rem5[i] >= 9'(oa4)) rem5[i] = rem5[i] - 9'(oa4);
      end
    end
  end

  logic [7:0] r5 [3];
  logic [7:0] oa5;
  logic [7:0] res5 [4];
  logic       wr5, div5;

  always_ff @(posedge clk) begin
    if (rdy[5] && v[4]) begin
      oa5  <= oa4;
      wr5  <= wr4;
      div5 <= div4;
      for (int i = 0; i < 4; i++) res5[i] <= res4[i];
      for (int i = 0; i < 3; i++) r5[i] <= rem5[i][7:0];
    end
  end

  // ---------------- stage 6: eight fraction bits, output register ----------------
  logic [8:0] rem6 [3];
  logic [7:0] q6 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem6[i] = 9'(r5[i]);
      q6[i]   = '0;
      for (int b = 7; b >= 0; b--) begin
        rem6[i] = {rem6[i][7:0], 1'b0};
        if (rem6[i] >= 9'(oa5)) begin
          rem6[i] = rem6[i] - 9'(oa5);
          q6[i][b] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6] && v[5]) begin
      written   <= wr5;
      out_red   <= div5 ? q6[0] : res5[0];
      out_green <= div5 ? q6[1] : res5[1];
      out_blue  <= div5 ? q6[2] : res5[2];
      out_alpha <= div5 ? oa5 : res5[3];
    end
  end

  // divider stages only run with a nonzero, in-range divisor
  `RPBU_ASSERT_IMPL(a_div_oa_min, v[5] && div5, oa5 >= 8'd3)
  `RPBU_ASSERT_IMPL(a_rem_bound, v[5] && div5, r5[0] < oa5 && r5[1] < oa5 && r5[2] < oa5)
  `RPBU_ASSERT_IMPL(a_div_needs_write, v[4] && div4, wr4)
  `RPBU_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, v[1])
endmodule
